// ----- rtl/core/fpua_pkg.sv -----
// ----------------------------------------------------------------------------
// fpua_pkg
// Shared types and constants of the fixed pool unit allocator.
// ----------------------------------------------------------------------------
package fpua_pkg;

    // Entries of the free queue, set by the 8-bit unit index
    localparam int QUEUE_DEPTH = 256;
    localparam int POOL_UNITS_DEFAULT = 256;

    localparam logic [8:0] UNIT_COUNT_RESET = 9'd256;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_INVALID   = 2'd2;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture request, launch memory reads
        logic exec;   // decide, update memories and pointers, register result
    } fpua_cmd_t;

endpackage

// ----- rtl/core/fpua_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpua_ctrl
// Request sequencer: accept, execute state, result strobe.
// ----------------------------------------------------------------------------
module fpua_ctrl
    import fpua_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output fpua_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = (state_reg == ST_EXEC);
    assign done     = done_reg;
    assign cmd.load = start && (state_reg == ST_IDLE);
    assign cmd.exec = (state_reg == ST_EXEC);

endmodule

// ----- rtl/core/fpua_datapath.sv -----
// ----------------------------------------------------------------------------
// fpua_datapath
// Free queue, allocated-flag memory, bump counter and result registers.
// ----------------------------------------------------------------------------
module fpua_datapath
    import fpua_pkg::*;
#(
    parameter int POOL_UNITS = POOL_UNITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  fpua_cmd_t  cmd,
    input  logic       kind,
    input  logic [7:0] unit_index,
    input  logic       cfg_wr_en,
    input  logic [8:0] cfg_wr_data,
    output logic [1:0] status,
    output logic [7:0] granted_index
);

    // Flags are only kept for units that can ever be usable
    localparam int FLAG_DEPTH = (POOL_UNITS < QUEUE_DEPTH) ? POOL_UNITS : QUEUE_DEPTH;
    localparam int FLAG_AW    = $clog2(FLAG_DEPTH);
    localparam logic [8:0] LIMIT_CAP = 9'(FLAG_DEPTH);

    logic [7:0] queue_mem [QUEUE_DEPTH];
    logic       flag_mem  [FLAG_DEPTH];

    logic [FLAG_DEPTH-1:0] flag_valid_reg;
    logic [8:0]            unit_count_reg;
    logic [7:0]            head_reg;
    logic [7:0]            tail_reg;
    logic [8:0]            fill_reg;
    logic [8:0]            bump_reg;
    logic                  kind_reg;
    logic [7:0]            unit_reg;
    logic [7:0]            q_rdata_reg;
    logic                  flag_rdata_reg;
    logic [1:0]            status_reg;
    logic [7:0]            granted_reg;

    logic [7:0]         head_next;
    logic [7:0]         tail_next;
    logic [8:0]         fill_next;
    logic [8:0]         bump_next;
    logic [1:0]         status_next;
    logic [7:0]         granted_next;
    logic [8:0]         limit;
    logic               flag_set;
    logic               flag_we;
    logic               flag_wdata;
    logic [FLAG_AW-1:0] flag_waddr;
    logic               queue_we;

    assign limit    = (unit_count_reg > LIMIT_CAP) ? LIMIT_CAP : unit_count_reg;
    // An entry never written since reset reads as cleared
    assign flag_set = flag_valid_reg[unit_reg[FLAG_AW-1:0]] && flag_rdata_reg;

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        bump_next    = bump_reg;
        status_next  = STATUS_OK;
        granted_next = 8'd0;
        flag_we      = 1'b0;
        flag_wdata   = 1'b0;
        flag_waddr   = unit_reg[FLAG_AW-1:0];
        queue_we     = 1'b0;
        if (kind_reg == KIND_ALLOC)
        begin
            if (fill_reg != 9'd0)
            begin
                // Reuse the oldest freed unit
                granted_next = q_rdata_reg;
                head_next    = head_reg + 8'd1;
                fill_next    = fill_reg - 9'd1;
                flag_we      = 1'b1;
                flag_wdata   = 1'b1;
                flag_waddr   = q_rdata_reg[FLAG_AW-1:0];
            end
            else if (bump_reg >= limit)
            begin
                status_next = STATUS_EXHAUSTED;
            end
            else
            begin
                granted_next = bump_reg[7:0];
                bump_next    = bump_reg + 9'd1;
                flag_we      = 1'b1;
                flag_wdata   = 1'b1;
                flag_waddr   = bump_reg[FLAG_AW-1:0];
            end
        end
        else
        begin
            if (({1'b0, unit_reg} >= limit) || !flag_set || fill_reg[8])
            begin
                status_next = STATUS_INVALID;
            end
            else
            begin
                flag_we   = 1'b1;
                queue_we  = 1'b1;
                tail_next = tail_reg + 8'd1;
                fill_next = fill_reg + 9'd1;
            end
        end
    end

    // Memory reads launch at the transfer, data is ready in the execute cycle
    always_ff @(posedge clk)
    begin
        q_rdata_reg    <= queue_mem[head_reg];
        flag_rdata_reg <= flag_mem[unit_index[FLAG_AW-1:0]];
        if (cmd.exec && queue_we)
        begin
            queue_mem[tail_reg] <= unit_reg;
        end
        if (cmd.exec && flag_we)
        begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        if (cmd.load)
        begin
            kind_reg <= kind;
            unit_reg <= unit_index;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_valid_reg <= '0;
            unit_count_reg <= UNIT_COUNT_RESET;
            head_reg       <= 8'd0;
            tail_reg       <= 8'd0;
            fill_reg       <= 9'd0;
            bump_reg       <= 9'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unit_count_reg <= cfg_wr_data;
            end
            if (cmd.exec)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                fill_reg <= fill_next;
                bump_reg <= bump_next;
                if (flag_we)
                begin
                    flag_valid_reg[flag_waddr] <= 1'b1;
                end
            end
        end
    end

    assign status        = status_reg;
    assign granted_index = granted_reg;

endmodule

// ----- rtl/core/fixed_pool_unit_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_pool_unit_allocator_unit
// Allocator for a pool of equal-sized units with a free queue and bump counter.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result shows on
// status and granted_index, marked by done for exactly one cycle, once the
// execute state registers it; the receiver cannot stall it, so capture it on
// done. Busy is high for the one cycle in between, so a new request can be
// taken in the cycle done is shown but not while one executes, owing to the
// registered read of the free queue and flag memory at the transfer and the
// read-modify-write of both in the execute cycle. Writes to unit_count take
// effect for the next request; the user must write only while idle (unchecked).
module fixed_pool_unit_allocator_unit
    import fpua_pkg::*;
#(
    parameter int POOL_UNITS = POOL_UNITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       kind,
    input  logic [7:0] unit_index,
    input  logic       cfg_wr_en,
    input  logic [8:0] cfg_wr_data,
    output logic       done,
    output logic [1:0] status,
    output logic [7:0] granted_index
);

    fpua_cmd_t cmd;

    fpua_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    fpua_datapath #(
        .POOL_UNITS (POOL_UNITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .kind          (kind),
        .unit_index    (unit_index),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .status        (status),
        .granted_index (granted_index)
    );

endmodule

// ----- rtl/core/fpua_checker.sv -----
// ----------------------------------------------------------------------------
// fpua_checker
// Port-level timing and result checks of the allocator.
// ----------------------------------------------------------------------------
module fpua_checker
    import fpua_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status,
    input logic [7:0] granted_index
);

    // A transfer leads to a busy cycle with no result yet
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("transfer not followed by busy cycle");

    // The busy cycle ends with the result strobe
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("busy cycle not followed by result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STATUS_OK || status == STATUS_EXHAUSTED ||
                  status == STATUS_INVALID))
        else $error("undefined status code");

    // Failed requests grant nothing
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (granted_index == 8'd0))
        else $error("nonzero grant on failed request");

endmodule

bind fixed_pool_unit_allocator_unit fpua_checker u_fpua_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .granted_index (granted_index)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed pool unit allocator: drives allocate and
// free commands with random idle gaps, predicts every status and granted unit
// from its own model of the free queue, bump counter and allocation flags,
// and compares each strobed result in order of transfer.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [1:0] status;
    logic [7:0] granted;
} grant_outcome_t;

class pool_scoreboard;
    logic [8:0]     unit_count;
    logic [8:0]     bump_next;
    bit             held [256];
    logic [7:0]     freed_units [$];
    grant_outcome_t outcomes [$];
    int unsigned    errors;

    function new();
        unit_count = fpua_pkg::UNIT_COUNT_RESET;
        bump_next  = '0;
        errors     = 0;
        foreach (held[i]) held[i] = 1'b0;
    endfunction

    function void set_unit_count(logic [8:0] value);
        unit_count = value;
    endfunction

    function int unsigned pending();
        return outcomes.size();
    endfunction

    // Units above the pool size or the 8-bit index reach are never usable
    function int unsigned usable_units();
        int unsigned lim;
        lim = unit_count;
        if (lim > fpua_pkg::POOL_UNITS_DEFAULT) lim = fpua_pkg::POOL_UNITS_DEFAULT;
        if (lim > fpua_pkg::QUEUE_DEPTH) lim = fpua_pkg::QUEUE_DEPTH;
        return lim;
    endfunction

    // Pick a unit that is currently allocated, so most frees are legal
    function logic [7:0] pick_held_unit();
        int unsigned candidates [$];
        for (int i = 0; i < 256; i++)
            if (held[i]) candidates.push_back(i);
        if (candidates.size() == 0) return 8'($urandom_range(255));
        return 8'(candidates[$urandom_range(candidates.size() - 1)]);
    endfunction

    function void note_request(logic req_kind, logic [7:0] idx);
        grant_outcome_t o;
        int unsigned    lim;
        lim       = usable_units();
        o.status  = fpua_pkg::STATUS_OK;
        o.granted = '0;
        if (req_kind == fpua_pkg::KIND_ALLOC) begin
            if (freed_units.size() != 0) begin
                o.granted = freed_units.pop_front();
                held[o.granted] = 1'b1;
            end else if (bump_next >= lim) begin
                o.status = fpua_pkg::STATUS_EXHAUSTED;
            end else begin
                o.granted = bump_next[7:0];
                bump_next = bump_next + 9'd1;
                held[o.granted] = 1'b1;
            end
        end else if (idx >= lim || !held[idx] || freed_units.size() >= fpua_pkg::QUEUE_DEPTH) begin
            o.status = fpua_pkg::STATUS_INVALID;
        end else begin
            held[idx] = 1'b0;
            freed_units.push_back(idx);
        end
        outcomes.push_back(o);
    endfunction

    task report_mismatch(string msg);
        if (errors < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(logic [1:0] got_status, logic [7:0] got_granted);
        grant_outcome_t want;
        if (outcomes.size() == 0) begin
            report_mismatch("result with no request outstanding");
            return;
        end
        want = outcomes.pop_front();
        if (got_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
        if (got_granted !== want.granted)
            report_mismatch($sformatf("granted_index %0d, expected %0d",
                                      got_granted, want.granted));
    endtask
endclass

module testbench;
    import fpua_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       kind = KIND_ALLOC;
    logic [7:0] unit_index = '0;
    logic       cfg_wr_en = 1'b0;
    logic [8:0] cfg_wr_data = '0;
    logic       busy;
    logic       done;
    logic [1:0] status;
    logic [7:0] granted_index;

    int unsigned    idle_pct = 0;
    pool_scoreboard sb = new();

    fixed_pool_unit_allocator_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .unit_index    (unit_index),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .done          (done),
        .status        (status),
        .granted_index (granted_index)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1) sb.check_result(status, granted_index);
    end

    // Hold the command until the transfer, idling first at random
    task automatic send_request(input logic req_kind, input logic [7:0] idx);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        kind       <= req_kind;
        unit_index <= idx;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_request(req_kind, idx);
    endtask

    // Drain all results, then write the count while the block is idle
    task automatic write_unit_count(input logic [8:0] value);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_unit_count(value);
        @(posedge clk);
    endtask

    task automatic run_random_phase(input int unsigned n_items);
        int unsigned alloc_pct;
        logic [7:0]  idx;
        alloc_pct = 90;
        for (int i = 0; i < n_items; i++)
        begin
            // Swing occupancy between filling and draining the pool
            if (i % 40 == 0) alloc_pct = (i % 120 == 0) ? 90 : (i % 120 == 40) ? 50 : 20;
            if ($urandom_range(99) < alloc_pct) begin
                send_request(KIND_ALLOC, 8'($urandom_range(255)));
            end else begin
                idx = ($urandom_range(99) < 75) ? sb.pick_held_unit()
                                                : 8'($urandom_range(255));
                send_request(KIND_FREE, idx);
            end
        end
    endtask

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [8:0] phase_counts [10];
        int unsigned idle_modes [3];
        phase_counts = '{9'd256, 9'd1, 9'd511, 9'd300, 9'd2, 9'd64, 9'd0, 9'd256,
                         9'd137, 9'd256};
        idle_modes   = '{0, 64, 13};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset count, reuse order, double free, lowered, zero and oversized counts
        send_request(KIND_FREE, 8'd0);
        send_request(KIND_ALLOC, 8'hFF);
        send_request(KIND_ALLOC, 8'h00);
        send_request(KIND_ALLOC, 8'h55);
        send_request(KIND_FREE, 8'd1);
        send_request(KIND_FREE, 8'd1);
        send_request(KIND_ALLOC, 8'h00);
        send_request(KIND_FREE, 8'd255);
        send_request(KIND_FREE, 8'd2);
        send_request(KIND_FREE, 8'd0);
        send_request(KIND_ALLOC, 8'h00);
        send_request(KIND_ALLOC, 8'hAA);
        send_request(KIND_FREE, 8'hAA);
        write_unit_count(9'd2);
        send_request(KIND_ALLOC, 8'h00);
        send_request(KIND_FREE, 8'd2);
        send_request(KIND_FREE, 8'd1);
        send_request(KIND_ALLOC, 8'h00);
        write_unit_count(9'd0);
        send_request(KIND_ALLOC, 8'h00);
        send_request(KIND_FREE, 8'd0);
        write_unit_count(9'd511);
        send_request(KIND_FREE, 8'd2);
        send_request(KIND_ALLOC, 8'h00);
        send_request(KIND_ALLOC, 8'hFF);
        write_unit_count(9'd1);
        send_request(KIND_ALLOC, 8'h00);
        send_request(KIND_FREE, 8'd0);
        send_request(KIND_ALLOC, 8'h00);

        for (int p = 0; p < 10; p++)
        begin
            write_unit_count(phase_counts[p]);
            idle_pct = idle_modes[p % 3];
            run_random_phase(p == 0 ? 300 : 95);
        end

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/fpua_pkg.sv
rtl/core/fpua_ctrl.sv
rtl/core/fpua_datapath.sv
rtl/core/fixed_pool_unit_allocator_unit.sv
rtl/core/fpua_checker.sv
bench/testbench.sv
